>>> src/kca_pkg.sv
// Package for the key click and autorepeat block: key table, register codes, helpers.
package kca_pkg;

  localparam int NUM_KEYS  = 14;
  localparam int KEY_IDX_W = 4;
  localparam int WORD_W    = 32;
  localparam int DELAY_W   = 16;
  localparam int TICK_W    = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [DELAY_W-1:0] INITIAL_DELAY_RST = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST  = 16'd175;

  // Register index codes, taken from paddr[2]
  localparam logic REG_INITIAL_DELAY = 1'b0;
  localparam logic REG_REPEAT_DELAY  = 1'b1;

  typedef logic [NUM_KEYS-1:0]  key_vec_t;
  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  localparam logic [WORD_W-1:0] KEY_MASK [NUM_KEYS] = '{
    32'h0100_0000, 32'h0400_0000, 32'h0080_0000,
    32'h0000_1000, 32'h0000_2000, 32'h0000_4000, 32'h0000_8000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000,
    32'h0000_0003, 32'h0000_0002, 32'h0000_0001
  };

  // 0 selects word a, 1 selects word b
  localparam logic KEY_WORD [NUM_KEYS] = '{
    1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  // A key is down when every one of its mask bits is low
  function automatic key_vec_t keys_down(input logic [WORD_W-1:0] wa,
                                         input logic [WORD_W-1:0] wb);
    key_vec_t d;
    d = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      d[k] = ((KEY_WORD[k] ? wb : wa) & KEY_MASK[k]) == '0;
    end
    return d;
  endfunction

endpackage

>>> src/key_click_autorepeat_top.sv
// Key click detection and typematic autorepeat, with APB delay registers.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  input    | in_valid/in_stall  | req_type, scan_word_a, scan_word_b, tick_now
//  output   | out_valid/out_stall| key_valid, key_index
//  config   | APB psel/penable   | paddr, pwdata, prdata (initial/repeat delay)
//
// One item per cycle while the result is not stalled; each result passes the input
// register, then key encoder and tick compare, then the result register.
// Reset (synchronous) sets both scan words to all ones, clears the repeat key
// and loads the delays with 500 and 175 ticks.
// A stalled result holds both stages; the input register still takes a
// transaction while it is empty.
module key_click_autorepeat_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         req_type,
  input  logic [kca_pkg::WORD_W-1:0]   scan_word_a,
  input  logic [kca_pkg::WORD_W-1:0]   scan_word_b,
  input  logic [kca_pkg::TICK_W-1:0]   tick_now,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         key_valid,
  output logic [kca_pkg::KEY_IDX_W-1:0] key_index,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [kca_pkg::ADDR_W-1:0]   paddr,
  input  logic [kca_pkg::DATA_W-1:0]   pwdata,
  output logic [kca_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import kca_pkg::*;

  // configuration
  logic [DELAY_W-1:0] initial_delay;
  logic [DELAY_W-1:0] repeat_delay;

  // input register
  logic              s1_valid;
  logic              s1_req_type;
  logic [WORD_W-1:0] s1_word_a;
  logic [WORD_W-1:0] s1_word_b;
  logic [TICK_W-1:0] s1_tick;

  // block state
  logic [WORD_W-1:0] cur_word_a;
  logic [WORD_W-1:0] cur_word_b;
  logic              repeat_active;
  key_idx_t          repeat_key;
  logic [TICK_W-1:0] last_emit_tick;
  logic              has_repeated;

  logic              advance;
  logic              take_in;
  logic              work;

  key_vec_t          down_now;
  key_vec_t          down_before;
  key_vec_t          click;
  logic              any_click;
  key_idx_t          click_idx;
  logic [TICK_W-1:0] elapsed;
  logic [DELAY_W-1:0] limit;
  logic              held;
  logic              due;

  logic              repeat_active_next;
  key_idx_t          repeat_key_next;
  logic [TICK_W-1:0] last_emit_tick_next;
  logic              has_repeated_next;
  logic              key_valid_next;
  key_idx_t          key_index_next;

  assign pready   = 1'b1;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;
  assign work     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_delay <= INITIAL_DELAY_RST;
      repeat_delay  <= REPEAT_DELAY_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_INITIAL_DELAY: initial_delay <= pwdata[DELAY_W-1:0];
        REG_REPEAT_DELAY:  repeat_delay  <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_INITIAL_DELAY: prdata = {{(DATA_W-DELAY_W){1'b0}}, initial_delay};
      REG_REPEAT_DELAY:  prdata = {{(DATA_W-DELAY_W){1'b0}}, repeat_delay};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      s1_req_type <= req_type;
      s1_word_a   <= scan_word_a;
      s1_word_b   <= scan_word_b;
      s1_tick     <= tick_now;
    end
  end

  always_comb begin
    down_now    = keys_down(s1_word_a, s1_word_b);
    down_before = keys_down(cur_word_a, cur_word_b);
    click       = down_now & ~down_before;
    any_click   = |click;
    click_idx   = '0;
    // walk down so the lowest table index wins
    for (int k = NUM_KEYS - 1; k >= 0; k--) begin
      if (click[k]) click_idx = KEY_IDX_W'(k);
    end
    elapsed = s1_tick - last_emit_tick;
    limit   = has_repeated ? repeat_delay : initial_delay;
    held    = repeat_active && down_now[repeat_key];
    due     = elapsed > {{(TICK_W-DELAY_W){1'b0}}, limit};

    repeat_active_next  = repeat_active;
    repeat_key_next     = repeat_key;
    last_emit_tick_next = last_emit_tick;
    has_repeated_next   = has_repeated;
    key_valid_next      = 1'b0;
    key_index_next      = '0;

    if (s1_req_type) begin
      repeat_active_next = 1'b0;
      repeat_key_next    = '0;
    end else if (any_click) begin
      repeat_active_next  = 1'b1;
      repeat_key_next     = click_idx;
      has_repeated_next   = 1'b0;
      last_emit_tick_next = s1_tick;
      key_valid_next      = 1'b1;
      key_index_next      = click_idx;
    end else if (held) begin
      if (due) begin
        has_repeated_next   = 1'b1;
        last_emit_tick_next = s1_tick;
        key_valid_next      = 1'b1;
        key_index_next      = repeat_key;
      end
    end else begin
      // repeat key released: forget it
      repeat_active_next = 1'b0;
      repeat_key_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word_a     <= '1;
      cur_word_b     <= '1;
      repeat_active  <= 1'b0;
      repeat_key     <= '0;
      last_emit_tick <= '0;
      has_repeated   <= 1'b0;
    end else if (work) begin
      if (!s1_req_type) begin
        cur_word_a <= s1_word_a;
        cur_word_b <= s1_word_b;
      end
      repeat_active  <= repeat_active_next;
      repeat_key     <= repeat_key_next;
      last_emit_tick <= last_emit_tick_next;
      has_repeated   <= has_repeated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (work) begin
      key_valid <= key_valid_next;
      key_index <= key_index_next;
    end
  end

  a_idle_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_valid |-> key_index == '0)
    else $error("silent result carries a non-zero key index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> key_index < KEY_IDX_W'(NUM_KEYS))
    else $error("reported key index beyond the key table");

  a_repeat_key_cleared: assert property (@(posedge clk) disable iff (rst)
    !repeat_active |-> repeat_key == '0)
    else $error("repeat key kept without an active repeat");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled while the pipeline could move");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    work && s1_req_type |=> out_valid && !key_valid && !repeat_active)
    else $error("clear transaction reported a key or kept the repeat key");

endmodule

>>> tb/kca_tb_pkg.sv
// Request kinds shared by the key click testbench top and its checker.
package kca_tb_pkg;

  typedef enum logic {
    REQ_SCAN  = 1'b0,
    REQ_CLEAR = 1'b1
  } req_kind_e;

endpackage

>>> tb/kca_checker.sv
// Checker for the key click block: predicts each key report from the channel traffic.
module kca_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          req_type,
  input  logic [kca_pkg::WORD_W-1:0]    scan_word_a,
  input  logic [kca_pkg::WORD_W-1:0]    scan_word_b,
  input  logic [kca_pkg::TICK_W-1:0]    tick_now,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          key_valid,
  input  logic [kca_pkg::KEY_IDX_W-1:0] key_index,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kca_pkg::ADDR_W-1:0]    paddr,
  input  logic [kca_pkg::DATA_W-1:0]    pwdata,
  input  logic [kca_pkg::DATA_W-1:0]    prdata,
  input  logic                          pready,
  output int                            failures,
  output int                            pending,
  output int                            clicks,
  output int                            repeats,
  output int                            clears,
  output int                            scans
);
  import kca_pkg::*;
  import kca_tb_pkg::*;

  typedef struct packed {
    logic           key_valid;
    logic [KEY_IDX_W-1:0] key_index;
  } key_report_t;

  // Key table: bits that must all be low, and which word they sit in
  localparam logic [31:0] PRESS_BITS [14] = '{
    32'h0100_0000, 32'h0400_0000, 32'h0080_0000,
    32'h0000_1000, 32'h0000_2000, 32'h0000_4000, 32'h0000_8000,
    32'h0001_0000, 32'h0002_0000, 32'h0004_0000, 32'h0008_0000,
    32'h0000_0003, 32'h0000_0002, 32'h0000_0001
  };
  localparam bit IN_WORD_B [14] = '{
    1'b0, 1'b0, 1'b0,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
  };

  key_report_t          due_reports [$];
  logic [DELAY_W-1:0]   first_delay, later_delay;
  logic [31:0]          prev_a, prev_b, cur_a, cur_b;
  logic                 rpt_armed, rpt_done_once;
  logic [KEY_IDX_W-1:0] rpt_key;
  logic [31:0]          rpt_last_tick;

  initial begin
    failures = 0;
    pending  = 0;
    clicks   = 0;
    repeats  = 0;
    clears   = 0;
    scans    = 0;
  end

  function automatic logic is_down(logic [31:0] wa, logic [31:0] wb, int k);
    return ((IN_WORD_B[k] ? wb : wa) & PRESS_BITS[k]) == 32'd0;
  endfunction

  function automatic key_report_t typematic_step(logic rt, logic [31:0] wa, logic [31:0] wb,
                                                 logic [31:0] tk);
    key_report_t r;
    logic [31:0] elapsed;
    logic [31:0] limit;
    r = '0;
    if (rt == REQ_CLEAR) begin
      rpt_armed = 1'b0;
      rpt_key   = '0;
      clears++;
      return r;
    end
    scans++;
    prev_a = cur_a;
    prev_b = cur_b;
    cur_a  = wa;
    cur_b  = wb;
    for (int k = 0; k < 14; k++) begin
      if (is_down(cur_a, cur_b, k) && !is_down(prev_a, prev_b, k)) begin
        rpt_armed     = 1'b1;
        rpt_key       = k[KEY_IDX_W-1:0];
        rpt_done_once = 1'b0;
        rpt_last_tick = tk;
        r.key_valid   = 1'b1;
        r.key_index   = k[KEY_IDX_W-1:0];
        clicks++;
        return r;
      end
    end
    if (rpt_armed && is_down(cur_a, cur_b, int'(rpt_key))) begin
      elapsed = tk - rpt_last_tick;
      limit   = {16'd0, rpt_done_once ? later_delay : first_delay};
      if (elapsed > limit) begin
        rpt_done_once = 1'b1;
        rpt_last_tick = tk;
        r.key_valid   = 1'b1;
        r.key_index   = rpt_key;
        repeats++;
      end
    end else begin
      // held key let go: forget it
      rpt_armed = 1'b0;
      rpt_key   = '0;
    end
    return r;
  endfunction

  task automatic flag(string what, logic [31:0] want, logic [31:0] got);
    if (failures < 10)
      $display("MISMATCH %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
    failures++;
  endtask

  always @(posedge clk) begin : monitor
    key_report_t want;
    logic [DELAY_W-1:0] reg_value;
    if (rst) begin
      due_reports.delete();
      first_delay   = INITIAL_DELAY_RST;
      later_delay   = REPEAT_DELAY_RST;
      prev_a        = '1;
      prev_b        = '1;
      cur_a         = '1;
      cur_b         = '1;
      rpt_armed     = 1'b0;
      rpt_key       = '0;
      rpt_last_tick = '0;
      rpt_done_once = 1'b0;
    end else begin
      if (psel && penable && pready) begin
        reg_value = (paddr[2] == REG_INITIAL_DELAY) ? first_delay : later_delay;
        if (pwrite) begin
          if (paddr[2] == REG_INITIAL_DELAY) first_delay = pwdata[DELAY_W-1:0];
          else later_delay = pwdata[DELAY_W-1:0];
        end else if (prdata !== {16'd0, reg_value}) begin
          flag("register read", {16'd0, reg_value}, prdata);
        end
      end
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          flag("report with nothing due, key_index", 32'd0, {28'd0, key_index});
        end else begin
          want = due_reports.pop_front();
          if (key_valid !== want.key_valid)
            flag("key_valid", {31'd0, want.key_valid}, {31'd0, key_valid});
          if (key_index !== want.key_index)
            flag("key_index", {28'd0, want.key_index}, {28'd0, key_index});
        end
      end
      if (in_valid && !in_stall)
        due_reports.push_back(typematic_step(req_type, scan_word_a, scan_word_b, tick_now));
    end
    pending = due_reports.size();
  end

endmodule

>>> tb/testbench.sv
// Testbench top for the key click block: clock, reset, stimulus, receiver stalls, verdict.
module testbench;
  import kca_pkg::*;
  import kca_tb_pkg::*;

  localparam int          IDLE_LIMIT = 2000;
  // table bits in each word; random extras stay off these
  localparam logic [31:0] KEY_BITS_A = 32'h0580_0000;
  localparam logic [31:0] KEY_BITS_B = 32'h000F_F003;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } scan_pair_t;

  localparam scan_pair_t NO_KEYS = '1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = REQ_SCAN;
  logic [WORD_W-1:0]    scan_word_a = '1;
  logic [WORD_W-1:0]    scan_word_b = '1;
  logic [TICK_W-1:0]    tick_now = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 key_valid;
  logic [KEY_IDX_W-1:0] key_index;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_W-1:0]    paddr = '0;
  logic [DATA_W-1:0]    pwdata = '0;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  int failures, pending, clicks, repeats, clears, scans;
  int hold_requests = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  logic [31:0] tick = 32'h0000_1000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_click_autorepeat_top i_dut (.*);

  kca_checker i_checker (.*);

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stall modes that change now and then, plus long hold-offs on request
  initial begin : receiver
    int mode;
    int mode_left;
    int hold_left;
    int holds_done;
    mode       = 0;
    mode_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && holds_done != hold_requests) begin
        hold_left = $urandom_range(40, 80);
        holds_done++;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((mode_left % 4) == 0);
        endcase
      end
    end
  end

  function automatic scan_pair_t press(scan_pair_t w, int k);
    if (KEY_WORD[k]) w.b = w.b & ~KEY_MASK[k];
    else w.a = w.a & ~KEY_MASK[k];
    return w;
  endfunction

  function automatic scan_pair_t noise_pair();
    scan_pair_t w;
    w.a = $urandom;
    w.b = $urandom;
    return w;
  endfunction

  // Offer one transaction, in bursts with random gaps; return at the accepting edge
  task automatic offer(req_kind_e kind, scan_pair_t w, logic [31:0] t);
    int   gap;
    logic taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    req_type    <= kind;
    scan_word_a <= w.a;
    scan_word_b <= w.b;
    tick_now    <= t;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // Stop sending and wait until every report has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_cycle(logic wr, logic sel, logic [DELAY_W-1:0] value);
    logic [31:0] junk;
    junk = $urandom;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {sel, 2'b00};
    pwdata  <= {junk[31:16], value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_delays(logic [DELAY_W-1:0] first, logic [DELAY_W-1:0] later);
    drain();
    apb_cycle(1'b1, REG_INITIAL_DELAY, first);
    apb_cycle(1'b1, REG_REPEAT_DELAY, later);
    apb_cycle(1'b0, REG_INITIAL_DELAY, '0);
    apb_cycle(1'b0, REG_REPEAT_DELAY, '0);
  endtask

  // Mostly held-key sequences with random content, the rest noise, clears and tick jumps
  task automatic random_phase(int items, int unsigned max_step);
    int         sent;
    int         hold;
    scan_pair_t w;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        7: begin
          tick += $urandom_range(0, max_step);
          offer(REQ_SCAN, noise_pair(), tick);
          sent++;
        end
        8: begin
          offer(REQ_CLEAR, noise_pair(), $urandom);
          sent++;
        end
        9: begin
          if ($urandom_range(0, 1)) tick = $urandom;
          else tick = 32'hFFFF_FFFF - $urandom_range(0, max_step);
        end
        default: begin
          w = press(NO_KEYS, $urandom_range(0, NUM_KEYS - 1));
          if ($urandom_range(0, 3) == 0) w = press(w, $urandom_range(0, NUM_KEYS - 1));
          if ($urandom_range(0, 4) == 0) begin
            w.a &= $urandom | KEY_BITS_A;
            w.b &= $urandom | KEY_BITS_B;
          end
          hold = $urandom_range(1, 12);
          for (int j = 0; j <= hold; j++) begin
            tick += $urandom_range(0, max_step);
            if (j > 0 && $urandom_range(0, 15) == 0) offer(REQ_CLEAR, noise_pair(), tick);
            else offer(REQ_SCAN, w, tick);
            sent++;
          end
          tick += $urandom_range(0, max_step);
          offer(REQ_SCAN, $urandom_range(0, 1) ? NO_KEYS : noise_pair(), tick);
          sent++;
        end
      endcase
    end
  endtask

  initial begin : stimulus
    logic [DELAY_W-1:0] d0, d1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk every key on its own; the two-bit key needs both of its bits low
    offer(REQ_SCAN, NO_KEYS, 32'd0);
    for (int k = 0; k < NUM_KEYS; k++) offer(REQ_SCAN, press(NO_KEYS, k), 32'd10 + k);
    // Hold everything: repeats only once elapsed ticks exceed the delay
    offer(REQ_SCAN, '0, 32'd100);
    offer(REQ_SCAN, '0, 32'd600);
    offer(REQ_SCAN, '0, 32'd601);
    offer(REQ_SCAN, '0, 32'd776);
    offer(REQ_SCAN, '0, 32'd777);
    offer(REQ_CLEAR, '0, 32'hFFFF_FFFF);
    offer(REQ_SCAN, '0, 32'hFFFF_FFF0);
    offer(REQ_SCAN, NO_KEYS, 32'hFFFF_FFF0);
    // Click just before the tick wraps, repeat after it
    offer(REQ_SCAN, press(NO_KEYS, 5), 32'hFFFF_FF00);
    offer(REQ_SCAN, press(NO_KEYS, 5), 32'h0000_00F5);
    offer(REQ_SCAN, press(NO_KEYS, 5), 32'h0000_01A5);
    offer(REQ_SCAN, NO_KEYS, 32'h0000_0200);

    set_delays('0, '0);
    hold_requests <= hold_requests + 1;
    random_phase(200, 3);
    set_delays('1, '1);
    random_phase(150, 40000);
    set_delays('1, '0);
    random_phase(150, 40000);
    set_delays('0, '1);
    random_phase(150, 40000);
    for (int p = 0; p < 5; p++) begin
      d0 = DELAY_W'($urandom_range(0, 600));
      d1 = DELAY_W'($urandom_range(0, 600));
      set_delays(d0, d1);
      if (p == 2) hold_requests <= hold_requests + 1;
      random_phase(110, ((d0 > d1) ? d0 : d1) / 4 + 4);
    end
    drain();

    $display("Covered %0d scans and %0d clears, giving %0d clicks and %0d repeats",
             scans, clears, clicks, repeats);
    $display("Delays swept from zero to 65535, with wrapped ticks and receiver hold-offs");
    if (failures == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
